// File: hdl/correlation_table_inverter_macros.svh
// Assertion helpers for the top-level block that checks its own behavior.
`ifndef CORRELATION_TABLE_INVERTER_MACROS_SVH
`define CORRELATION_TABLE_INVERTER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CTI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CTI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/cti_pkg.sv
`timescale 1ns / 1ps

package cti_pkg;

  // Default table geometry.
  localparam int SIGMA_POINTS_DEF = 64;
  localparam int RHO_POINTS_DEF   = 128;

  // Field and datapath widths.
  localparam int KIND_W    = 2;
  localparam int SPT_W     = 6;
  localparam int RPT_W     = 7;
  localparam int VAL_W     = 24;
  localparam int SIG_W     = 24;
  localparam int COV_W     = 25;
  localparam int MAG_W     = 25;
  localparam int CORR_W    = 24;
  localparam int STAT_W    = 3;
  localparam int RULER_W   = 23;
  localparam int LOCP_W    = 48;
  localparam int WFR_W     = 16;
  localparam int UW_W      = 17;
  localparam int WGT_W     = 33;
  localparam int ACC_W     = 57;
  localparam int BLEND_W   = 33;
  localparam int DR_W      = 23;
  localparam int DX_W      = 33;
  localparam int NUM_W     = 56;
  localparam int SUM_W     = 58;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 24;
  localparam int MD_CNT_W  = 6;

  // Input word kinds.
  localparam logic [KIND_W-1:0] KIND_TABLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RULER = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECIP = 2'd2;

  // Configuration reset values.
  localparam logic [CFG_W-1:0] START_RST = 24'd0;
  localparam logic [CFG_W-1:0] STEP_RST  = 24'd65536;
  localparam logic [CFG_W-1:0] RECIP_RST = 24'd65536;

  // Saturation values in Q1.22.
  localparam logic signed [CORR_W-1:0] NEAR_ONE = 24'sd4194303;
  localparam logic signed [SUM_W-1:0]  ONE_POS  = 58'sd4194304;
  localparam logic signed [SUM_W-1:0]  ONE_NEG  = -58'sd4194304;

  // Rounding constant for the blended value, half of Q8.24 LSB in Q8.48.
  localparam logic [ACC_W-1:0] BLEND_HALF = 57'h800000;

  // Last cycle of the blend sequence.
  localparam logic [2:0] BLEND_LAST = 3'd6;

  // Last iterations of the multiply and divide phases.
  localparam logic [MD_CNT_W-1:0] MUL_LAST = 6'(DR_W - 1);
  localparam logic [MD_CNT_W-1:0] DIV_LAST = 6'(NUM_W - 1);

  typedef enum logic [STAT_W-1:0] {
    ST_INTERP = 3'd0,
    ST_ZERO   = 3'd1,
    ST_ABOVE  = 3'd2,
    ST_SIGMA  = 3'd3,
    ST_FLAT   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    RSEL_TOP,
    RSEL_MID,
    RSEL_LO,
    RSEL_HI
  } rho_sel_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_ZERO_CHK,
    S_LOC_A,
    S_LOC_B,
    S_LOC_CHK,
    S_WEIGHT,
    S_BL_TOP,
    S_TOP_CHK,
    S_BIS_CHK,
    S_BL_MID,
    S_BIS_EVAL,
    S_FIX,
    S_BL_C0,
    S_BL_C1,
    S_RHO_LO,
    S_RHO_HI,
    S_FLAT_CHK,
    S_MULDIV,
    S_FINAL,
    S_DONE
  } ctrl_state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_phase_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       loc_a;
    logic       loc_b;
    logic       wgt_en;
    logic [1:0] wgt_sel;
    logic       blend_run;
    rho_sel_e   blend_sel;
    logic       bis_init;
    logic       bis_mid;
    logic       bis_lo;
    logic       bis_hi;
    logic       fix_hi;
    logic       c0_load;
    logic       rho_hi;
    logic       r0_load;
    logic       md_start;
    logic       res_load;
    status_e    res_code;
    logic       out_load;
  } cti_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mag_zero;
    logic off_ruler;
    logic x_gt_p;
    logic x_lt_p;
    logic gap_gt1;
    logic blend_done;
    logic den_zero;
    logic md_done;
  } cti_stat_t;

endpackage

// File: hdl/cti_if.sv
`timescale 1ns / 1ps

// Input channel: load words and queries.
interface cti_in_if;
  logic                       valid;
  logic                       ready;
  logic [cti_pkg::KIND_W-1:0] kind;
  logic [cti_pkg::SPT_W-1:0]  first_sigma_point;
  logic [cti_pkg::SPT_W-1:0]  second_sigma_point;
  logic [cti_pkg::RPT_W-1:0]  rho_point;
  logic [cti_pkg::VAL_W-1:0]  load_value;
  logic [cti_pkg::SIG_W-1:0]  sigma_a;
  logic [cti_pkg::SIG_W-1:0]  sigma_b;
  logic signed [cti_pkg::COV_W-1:0] covariance;
  logic                       batch_end;

  modport source (
    output valid, kind, first_sigma_point, second_sigma_point, rho_point,
           load_value, sigma_a, sigma_b, covariance, batch_end,
    input  ready
  );
  modport sink (
    input  valid, kind, first_sigma_point, second_sigma_point, rho_point,
           load_value, sigma_a, sigma_b, covariance, batch_end,
    output ready
  );
endinterface

// Output channel: one result word per query.
interface cti_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [cti_pkg::CORR_W-1:0]  correlation;
  logic [cti_pkg::STAT_W-1:0]         status;
  logic                               batch_end_out;

  modport source (output valid, correlation, status, batch_end_out, input ready);
  modport sink (input valid, correlation, status, batch_end_out, output ready);
endinterface

// File: hdl/cti_muldiv.sv
`timescale 1ns / 1ps

// Bit-serial unsigned multiply followed by restoring division:
// quot = (a * b) / den, one bit per cycle in each phase.
module cti_muldiv (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [cti_pkg::DR_W-1:0]    a_i,
  input  logic [cti_pkg::DX_W-1:0]    b_i,
  input  logic [cti_pkg::DX_W-1:0]    den_i,
  output logic                        done_o,
  output logic [cti_pkg::NUM_W-1:0]   quot_o
);

  cti_pkg::md_phase_e                phase_q, phase_d;
  logic [cti_pkg::MD_CNT_W-1:0]      cnt_q, cnt_d;
  logic                              done_q, done_d;
  logic [cti_pkg::NUM_W-1:0]         acc_q, acc_d;
  logic [cti_pkg::NUM_W-1:0]         mcand_q, mcand_d;
  logic [cti_pkg::DR_W-1:0]          mplier_q, mplier_d;
  logic [cti_pkg::DX_W-1:0]          rem_q, rem_d;
  logic [cti_pkg::DX_W-1:0]          den_q, den_d;
  logic [cti_pkg::DX_W:0]            rem_sh;
  logic                              ge;

  // One restoring step: shift in the next dividend bit and try a subtract.
  assign rem_sh = {rem_q, acc_q[cti_pkg::NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    done_d   = 1'b0;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    rem_d    = rem_q;
    den_d    = den_q;
    case (phase_q)
      cti_pkg::MD_IDLE: begin
        if (start_i) begin
          phase_d  = cti_pkg::MD_MUL;
          cnt_d    = '0;
          acc_d    = '0;
          mcand_d  = cti_pkg::NUM_W'(b_i);
          mplier_d = a_i;
          den_d    = den_i;
        end
      end
      cti_pkg::MD_MUL: begin
        if (mplier_q[0]) begin
          acc_d = acc_q + mcand_q;
        end
        mcand_d  = {mcand_q[cti_pkg::NUM_W-2:0], 1'b0};
        mplier_d = {1'b0, mplier_q[cti_pkg::DR_W-1:1]};
        if (cnt_q == cti_pkg::MUL_LAST) begin
          phase_d = cti_pkg::MD_DIV;
          cnt_d   = '0;
          rem_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      cti_pkg::MD_DIV: begin
        rem_d = ge ? cti_pkg::DX_W'(rem_sh - {1'b0, den_q})
                   : rem_sh[cti_pkg::DX_W-1:0];
        acc_d = {acc_q[cti_pkg::NUM_W-2:0], ge};
        if (cnt_q == cti_pkg::DIV_LAST) begin
          phase_d = cti_pkg::MD_IDLE;
          done_d  = 1'b1;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: begin
        phase_d = cti_pkg::MD_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= cti_pkg::MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    rem_q    <= rem_d;
    den_q    <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = acc_q;

endmodule

// File: hdl/cti_datapath.sv
`timescale 1ns / 1ps

// Datapath: configuration, table and ruler memories, ruler location,
// bilinear blend engine, bisection indexes and result registers.
module cti_datapath #(
  parameter int SIGMA_POINTS = cti_pkg::SIGMA_POINTS_DEF,
  parameter int RHO_POINTS   = cti_pkg::RHO_POINTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cti_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [cti_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic [cti_pkg::KIND_W-1:0]      kind_i,
  input  logic [cti_pkg::SPT_W-1:0]       first_sigma_point_i,
  input  logic [cti_pkg::SPT_W-1:0]       second_sigma_point_i,
  input  logic [cti_pkg::RPT_W-1:0]       rho_point_i,
  input  logic [cti_pkg::VAL_W-1:0]       load_value_i,
  input  logic [cti_pkg::SIG_W-1:0]       sigma_a_i,
  input  logic [cti_pkg::SIG_W-1:0]       sigma_b_i,
  input  logic signed [cti_pkg::COV_W-1:0] covariance_i,
  input  logic                            batch_end_i,
  input  cti_pkg::cti_cmd_t               cmd_i,
  output cti_pkg::cti_stat_t              stat_o,
  output logic signed [cti_pkg::CORR_W-1:0] correlation_o,
  output logic [cti_pkg::STAT_W-1:0]      status_o,
  output logic                            batch_end_out_o
);

  localparam int SIW       = (SIGMA_POINTS > 1) ? $clog2(SIGMA_POINTS) : 1;
  localparam int RIW       = (RHO_POINTS > 1) ? $clog2(RHO_POINTS) : 1;
  localparam int TBL_DEPTH = SIGMA_POINTS * SIGMA_POINTS * RHO_POINTS;
  localparam int TAW       = $clog2(TBL_DEPTH);
  localparam logic [RIW-1:0] RHO_TOP = RIW'(RHO_POINTS - 1);

  // Configuration registers.
  logic [cti_pkg::CFG_W-1:0] start_q, step_q, recip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= cti_pkg::START_RST;
      step_q  <= cti_pkg::STEP_RST;
      recip_q <= cti_pkg::RECIP_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        cti_pkg::CFG_START: start_q <= cfg_data_i;
        cti_pkg::CFG_STEP:  step_q  <= cfg_data_i;
        cti_pkg::CFG_RECIP: recip_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Query capture.
  logic [cti_pkg::SIG_W-1:0] sig_a_q, sig_b_q;
  logic [cti_pkg::MAG_W-1:0] mag_q;
  logic                      neg_q, batch_q;
  logic [cti_pkg::MAG_W-1:0] mag_c;
  logic                      is_query, is_table, is_ruler;

  assign is_query = cmd_i.capture && (kind_i == cti_pkg::KIND_QUERY);
  assign is_table = cmd_i.capture && (kind_i == cti_pkg::KIND_TABLE);
  assign is_ruler = cmd_i.capture && (kind_i == cti_pkg::KIND_RULER);
  assign mag_c    = covariance_i[cti_pkg::COV_W-1] ? (~covariance_i + 1'b1) : covariance_i;

  always_ff @(posedge clk_i) begin
    if (is_query) begin
      sig_a_q <= sigma_a_i;
      sig_b_q <= sigma_b_i;
      mag_q   <= mag_c;
      neg_q   <= covariance_i[cti_pkg::COV_W-1];
      batch_q <= batch_end_i;
    end
  end

  // Ruler location: one multiplier shared by both sigmas.
  logic [cti_pkg::SIG_W-1:0]  loc_sig;
  logic [cti_pkg::LOCP_W-1:0] loc_prod;
  logic                       loc_off;
  logic [SIW-1:0]             ia_q, ib_q;
  logic [cti_pkg::WFR_W-1:0]  wa_q, wb_q;
  logic                       off_a_q, off_b_q;

  assign loc_sig  = cmd_i.loc_b ? sig_b_q : sig_a_q;
  assign loc_prod = cti_pkg::LOCP_W'(loc_sig - start_q) * cti_pkg::LOCP_W'(recip_q);
  assign loc_off  = (loc_sig < start_q) ||
                    (32'(loc_prod[cti_pkg::LOCP_W-1:32]) >= 32'(SIGMA_POINTS - 1));

  always_ff @(posedge clk_i) begin
    if (cmd_i.loc_a) begin
      ia_q    <= loc_prod[32 +: SIW];
      wa_q    <= loc_prod[31:16];
      off_a_q <= loc_off;
    end
    if (cmd_i.loc_b) begin
      ib_q    <= loc_prod[32 +: SIW];
      wb_q    <= loc_prod[31:16];
      off_b_q <= loc_off;
    end
  end

  // Corner weights, one product per cycle. Corner bit 0 steps sigma a,
  // corner bit 1 steps sigma b.
  logic [cti_pkg::UW_W-1:0]  wf_a, wf_b;
  logic [2*cti_pkg::UW_W-1:0] wf_prod;
  logic [cti_pkg::WGT_W-1:0] w_q [4];

  assign wf_a    = cmd_i.wgt_sel[0] ? {1'b0, wa_q} : (17'h10000 - {1'b0, wa_q});
  assign wf_b    = cmd_i.wgt_sel[1] ? {1'b0, wb_q} : (17'h10000 - {1'b0, wb_q});
  assign wf_prod = wf_a * wf_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wgt_en) begin
      w_q[cmd_i.wgt_sel] <= wf_prod[cti_pkg::WGT_W-1:0];
    end
  end

  // Bisection indexes.
  logic [RIW-1:0] lo_q, hi_q, mid_q;
  logic [RIW:0]   gap, mid_sum;

  assign gap     = {1'b0, hi_q} - {1'b0, lo_q};
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.bis_init) begin
      lo_q <= '0;
      hi_q <= RHO_TOP;
    end
    if (cmd_i.bis_mid) begin
      mid_q <= mid_sum[RIW:1];
    end
    if (cmd_i.bis_lo) begin
      lo_q <= mid_q;
    end
    if (cmd_i.bis_hi) begin
      hi_q <= mid_q;
    end
    if (cmd_i.fix_hi) begin
      hi_q <= lo_q + 1'b1;
    end
  end

  // Blend engine: reads the four corners through the one table port,
  // multiplies each by its weight and accumulates.
  logic [2:0]                 bcnt_q;
  logic [1:0]                 pcor;
  logic [RIW-1:0]             blend_r;
  logic [31:0]                ra, rb, raddr_full, waddr_full;
  logic [TAW-1:0]             raddr, waddr;
  logic [cti_pkg::VAL_W-1:0]  tbl_mem [TBL_DEPTH];
  logic [cti_pkg::VAL_W-1:0]  tbl_rd_q;
  logic [cti_pkg::WGT_W-1:0]  pw;
  logic [cti_pkg::ACC_W-1:0]  prod_q, acc_q, acc_rnd;
  logic [cti_pkg::BLEND_W-1:0] p_q, c0_q, x_c;
  logic                       tbl_we, blend_done;

  always_comb begin
    case (cmd_i.blend_sel)
      cti_pkg::RSEL_TOP: blend_r = RHO_TOP;
      cti_pkg::RSEL_MID: blend_r = mid_q;
      cti_pkg::RSEL_LO:  blend_r = lo_q;
      cti_pkg::RSEL_HI:  blend_r = hi_q;
      default:           blend_r = RHO_TOP;
    endcase
  end

  assign ra         = 32'(ia_q) + 32'(bcnt_q[0]);
  assign rb         = 32'(ib_q) + 32'(bcnt_q[1]);
  assign raddr_full = (ra * 32'(SIGMA_POINTS) + rb) * 32'(RHO_POINTS) + 32'(blend_r);
  assign raddr      = raddr_full[TAW-1:0];
  assign waddr_full = (32'(first_sigma_point_i) * 32'(SIGMA_POINTS)
                       + 32'(second_sigma_point_i)) * 32'(RHO_POINTS) + 32'(rho_point_i);
  assign waddr      = waddr_full[TAW-1:0];
  assign tbl_we     = is_table && (32'(first_sigma_point_i) < 32'(SIGMA_POINTS))
                      && (32'(second_sigma_point_i) < 32'(SIGMA_POINTS))
                      && (32'(rho_point_i) < 32'(RHO_POINTS));

  // Table memory.
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[waddr] <= load_value_i;
    end
    tbl_rd_q <= tbl_mem[raddr];
  end

  assign pcor       = 2'(bcnt_q - 3'd1);
  assign pw         = w_q[pcor];
  assign blend_done = cmd_i.blend_run && (bcnt_q == cti_pkg::BLEND_LAST);
  assign acc_rnd    = acc_q + cti_pkg::BLEND_HALF;
  assign x_c        = {mag_q, 8'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcnt_q <= '0;
    end else if (!cmd_i.blend_run || blend_done) begin
      bcnt_q <= '0;
    end else begin
      bcnt_q <= bcnt_q + 1'b1;
    end
  end

  // A full weight of one appears only when the other three are zero.
  always_ff @(posedge clk_i) begin
    prod_q <= pw[cti_pkg::WGT_W-1] ? {1'b0, tbl_rd_q, 32'b0}
                                   : cti_pkg::ACC_W'(tbl_rd_q * pw[31:0]);
    if (bcnt_q == 3'd0) begin
      acc_q <= '0;
    end else if (bcnt_q >= 3'd2 && bcnt_q <= 3'd5) begin
      acc_q <= acc_q + prod_q;
    end
    if (blend_done) begin
      p_q <= acc_rnd[cti_pkg::ACC_W-1:24];
    end
    if (cmd_i.c0_load && blend_done) begin
      c0_q <= acc_rnd[cti_pkg::ACC_W-1:24];
    end
  end

  // Rho ruler memory.
  localparam int RULER_AW = RIW;
  logic [RULER_AW-1:0]          rho_raddr;
  logic [cti_pkg::RULER_W-1:0]  rho_mem [RHO_POINTS];
  logic [cti_pkg::RULER_W-1:0]  rho_rd_q, r0_q;
  logic                         rho_we;

  assign rho_raddr = cmd_i.rho_hi ? hi_q : lo_q;
  assign rho_we    = is_ruler && (32'(rho_point_i) < 32'(RHO_POINTS));

  always_ff @(posedge clk_i) begin
    if (rho_we) begin
      rho_mem[rho_point_i[RIW-1:0]] <= load_value_i[cti_pkg::RULER_W-1:0];
    end
    rho_rd_q <= rho_mem[rho_raddr];
    if (cmd_i.r0_load) begin
      r0_q <= rho_rd_q;
    end
  end

  // Operands of (r1 - r0) * (x - c0) / (c1 - c0), as magnitudes and a sign.
  logic signed [cti_pkg::DR_W:0] dr;
  logic signed [cti_pkg::DX_W:0] dx, den;
  logic [cti_pkg::DR_W-1:0]      dr_mag;
  logic [cti_pkg::DX_W-1:0]      dx_mag, den_mag;
  logic                          q_neg_q, md_done;
  logic [cti_pkg::NUM_W-1:0]     quot;

  assign dr      = $signed({1'b0, rho_rd_q}) - $signed({1'b0, r0_q});
  assign dx      = $signed({1'b0, x_c}) - $signed({1'b0, c0_q});
  assign den     = $signed({1'b0, p_q}) - $signed({1'b0, c0_q});
  assign dr_mag  = dr[cti_pkg::DR_W] ? cti_pkg::DR_W'(-dr) : dr[cti_pkg::DR_W-1:0];
  assign dx_mag  = dx[cti_pkg::DX_W] ? cti_pkg::DX_W'(-dx) : dx[cti_pkg::DX_W-1:0];
  assign den_mag = den[cti_pkg::DX_W] ? cti_pkg::DX_W'(-den) : den[cti_pkg::DX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.md_start) begin
      q_neg_q <= dr[cti_pkg::DR_W] ^ dx[cti_pkg::DX_W] ^ den[cti_pkg::DX_W];
    end
  end

  cti_muldiv u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.md_start),
    .a_i     (dr_mag),
    .b_i     (dx_mag),
    .den_i   (den_mag),
    .done_o  (md_done),
    .quot_o  (quot)
  );

  // Interpolated rho, clamped to plus or minus one.
  logic signed [cti_pkg::SUM_W-1:0] sq, rsum;
  logic signed [cti_pkg::CORR_W-1:0] interp, res_val;
  logic signed [cti_pkg::CORR_W-1:0] res_q;
  cti_pkg::status_e                  res_st_q;

  assign sq   = $signed({2'b00, quot});
  assign rsum = $signed(cti_pkg::SUM_W'(r0_q)) + (q_neg_q ? -sq : sq);

  always_comb begin
    if (rsum > cti_pkg::ONE_POS) begin
      interp = cti_pkg::CORR_W'(cti_pkg::ONE_POS);
    end else if (rsum < cti_pkg::ONE_NEG) begin
      interp = cti_pkg::CORR_W'(cti_pkg::ONE_NEG);
    end else begin
      interp = rsum[cti_pkg::CORR_W-1:0];
    end
  end

  always_comb begin
    case (cmd_i.res_code)
      cti_pkg::ST_INTERP: res_val = interp;
      cti_pkg::ST_ABOVE:  res_val = cti_pkg::NEAR_ONE;
      cti_pkg::ST_SIGMA:  res_val = cti_pkg::NEAR_ONE;
      default:            res_val = '0;
    endcase
  end

  // Result and output registers; the covariance sign is restored on output.
  logic signed [cti_pkg::CORR_W-1:0] out_corr_q;
  logic [cti_pkg::STAT_W-1:0]        out_st_q;
  logic                              out_be_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_q    <= res_val;
      res_st_q <= cmd_i.res_code;
    end
    if (cmd_i.out_load) begin
      out_corr_q <= neg_q ? -res_q : res_q;
      out_st_q   <= res_st_q;
      out_be_q   <= batch_q;
    end
  end

  assign correlation_o   = out_corr_q;
  assign status_o        = out_st_q;
  assign batch_end_out_o = out_be_q;

  // Status toward the controller.
  assign stat_o.mag_zero   = (mag_q == '0);
  assign stat_o.off_ruler  = off_a_q || off_b_q;
  assign stat_o.x_gt_p     = x_c > p_q;
  assign stat_o.x_lt_p     = x_c < p_q;
  assign stat_o.gap_gt1    = gap > (RIW + 1)'(1);
  assign stat_o.blend_done = blend_done;
  assign stat_o.den_zero   = (p_q == c0_q);
  assign stat_o.md_done    = md_done;

endmodule

// File: hdl/cti_controller.sv
`timescale 1ns / 1ps

// Controller: sequences one query through location, weighting, bisection,
// interpolation and output; load words complete in their accept cycle.
module cti_controller (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [cti_pkg::KIND_W-1:0]  in_kind_i,
  output logic                        in_ready_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  input  cti_pkg::cti_stat_t          stat_i,
  output cti_pkg::cti_cmd_t           cmd_o
);

  cti_pkg::ctrl_state_e state_q, state_d;
  logic [1:0]           wcnt_q, wcnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 fire, slot_free;

  assign fire      = in_valid_i && (state_q == cti_pkg::S_IDLE);
  assign slot_free = !out_valid_q || out_ready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    wcnt_d  = wcnt_q;
    case (state_q)
      cti_pkg::S_IDLE: begin
        if (fire && (in_kind_i == cti_pkg::KIND_QUERY)) begin
          state_d = cti_pkg::S_ZERO_CHK;
        end
      end
      cti_pkg::S_ZERO_CHK: begin
        state_d = stat_i.mag_zero ? cti_pkg::S_DONE : cti_pkg::S_LOC_A;
      end
      cti_pkg::S_LOC_A: state_d = cti_pkg::S_LOC_B;
      cti_pkg::S_LOC_B: state_d = cti_pkg::S_LOC_CHK;
      cti_pkg::S_LOC_CHK: begin
        wcnt_d  = '0;
        state_d = stat_i.off_ruler ? cti_pkg::S_DONE : cti_pkg::S_WEIGHT;
      end
      cti_pkg::S_WEIGHT: begin
        wcnt_d = wcnt_q + 1'b1;
        if (wcnt_q == 2'd3) begin
          state_d = cti_pkg::S_BL_TOP;
        end
      end
      cti_pkg::S_BL_TOP: begin
        if (stat_i.blend_done) begin
          state_d = cti_pkg::S_TOP_CHK;
        end
      end
      cti_pkg::S_TOP_CHK: begin
        state_d = stat_i.x_gt_p ? cti_pkg::S_DONE : cti_pkg::S_BIS_CHK;
      end
      cti_pkg::S_BIS_CHK: begin
        state_d = stat_i.gap_gt1 ? cti_pkg::S_BL_MID : cti_pkg::S_FIX;
      end
      cti_pkg::S_BL_MID: begin
        if (stat_i.blend_done) begin
          state_d = cti_pkg::S_BIS_EVAL;
        end
      end
      cti_pkg::S_BIS_EVAL: begin
        if (stat_i.x_gt_p || stat_i.x_lt_p) begin
          state_d = cti_pkg::S_BIS_CHK;
        end else begin
          state_d = cti_pkg::S_FIX;
        end
      end
      cti_pkg::S_FIX: state_d = cti_pkg::S_BL_C0;
      cti_pkg::S_BL_C0: begin
        if (stat_i.blend_done) begin
          state_d = cti_pkg::S_BL_C1;
        end
      end
      cti_pkg::S_BL_C1: begin
        if (stat_i.blend_done) begin
          state_d = cti_pkg::S_RHO_LO;
        end
      end
      cti_pkg::S_RHO_LO: state_d = cti_pkg::S_RHO_HI;
      cti_pkg::S_RHO_HI: state_d = cti_pkg::S_FLAT_CHK;
      cti_pkg::S_FLAT_CHK: begin
        state_d = stat_i.den_zero ? cti_pkg::S_DONE : cti_pkg::S_MULDIV;
      end
      cti_pkg::S_MULDIV: begin
        if (stat_i.md_done) begin
          state_d = cti_pkg::S_FINAL;
        end
      end
      cti_pkg::S_FINAL: state_d = cti_pkg::S_DONE;
      cti_pkg::S_DONE: begin
        if (slot_free) begin
          state_d = cti_pkg::S_IDLE;
        end
      end
      default: state_d = cti_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o           = '0;
    cmd_o.blend_sel = cti_pkg::RSEL_TOP;
    cmd_o.res_code  = cti_pkg::ST_INTERP;
    cmd_o.wgt_sel   = wcnt_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    case (state_q)
      cti_pkg::S_IDLE: cmd_o.capture = fire;
      cti_pkg::S_ZERO_CHK: begin
        cmd_o.res_load = stat_i.mag_zero;
        cmd_o.res_code = cti_pkg::ST_ZERO;
      end
      cti_pkg::S_LOC_A: cmd_o.loc_a = 1'b1;
      cti_pkg::S_LOC_B: cmd_o.loc_b = 1'b1;
      cti_pkg::S_LOC_CHK: begin
        cmd_o.res_load = stat_i.off_ruler;
        cmd_o.res_code = cti_pkg::ST_SIGMA;
      end
      cti_pkg::S_WEIGHT: cmd_o.wgt_en = 1'b1;
      cti_pkg::S_BL_TOP: cmd_o.blend_run = 1'b1;
      cti_pkg::S_TOP_CHK: begin
        cmd_o.res_load = stat_i.x_gt_p;
        cmd_o.res_code = cti_pkg::ST_ABOVE;
        cmd_o.bis_init = !stat_i.x_gt_p;
      end
      cti_pkg::S_BIS_CHK: cmd_o.bis_mid = stat_i.gap_gt1;
      cti_pkg::S_BL_MID: begin
        cmd_o.blend_run = 1'b1;
        cmd_o.blend_sel = cti_pkg::RSEL_MID;
      end
      cti_pkg::S_BIS_EVAL: begin
        cmd_o.bis_hi = stat_i.x_lt_p;
        cmd_o.bis_lo = !stat_i.x_lt_p;
      end
      cti_pkg::S_FIX: cmd_o.fix_hi = 1'b1;
      cti_pkg::S_BL_C0: begin
        cmd_o.blend_run = 1'b1;
        cmd_o.blend_sel = cti_pkg::RSEL_LO;
        cmd_o.c0_load   = 1'b1;
      end
      cti_pkg::S_BL_C1: begin
        cmd_o.blend_run = 1'b1;
        cmd_o.blend_sel = cti_pkg::RSEL_HI;
      end
      cti_pkg::S_RHO_LO: cmd_o.rho_hi = 1'b0;
      cti_pkg::S_RHO_HI: begin
        cmd_o.rho_hi  = 1'b1;
        cmd_o.r0_load = 1'b1;
      end
      cti_pkg::S_FLAT_CHK: begin
        cmd_o.res_load = stat_i.den_zero;
        cmd_o.res_code = cti_pkg::ST_FLAT;
        cmd_o.md_start = !stat_i.den_zero;
      end
      cti_pkg::S_MULDIV: begin
      end
      cti_pkg::S_FINAL: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_code = cti_pkg::ST_INTERP;
      end
      cti_pkg::S_DONE: begin
        cmd_o.out_load = slot_free;
        if (slot_free) begin
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cti_pkg::S_IDLE;
      wcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wcnt_q      <= wcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == cti_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/correlation_table_inverter.sv
`timescale 1ns / 1ps
// Channel  Direction  Words
// in_i     sink       table loads, rho ruler loads, queries
// out_o    source     one correlation word per query
// Loads complete in their accept cycle. A query finishes sooner on an early
// exact hit: each bisection step runs the blend that reads four corners
// through the single table port, and the rho interpolation runs in the
// bit-serial multiplier and divider. Reset clears the control state and the
// configuration registers; memories hold garbage until loaded. A stalled
// output word waits in its register while the next input word is taken.
`include "correlation_table_inverter_macros.svh"

module correlation_table_inverter #(
  parameter int SIGMA_POINTS = cti_pkg::SIGMA_POINTS_DEF,
  parameter int RHO_POINTS   = cti_pkg::RHO_POINTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cti_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [cti_pkg::CFG_W-1:0]     cfg_data_i,
  cti_in_if.sink                        in_i,
  cti_out_if.source                     out_o
);

  cti_pkg::cti_cmd_t  cmd;
  cti_pkg::cti_stat_t stat;

  cti_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_kind_i   (in_i.kind),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  cti_datapath #(
    .SIGMA_POINTS (SIGMA_POINTS),
    .RHO_POINTS   (RHO_POINTS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .kind_i               (in_i.kind),
    .first_sigma_point_i  (in_i.first_sigma_point),
    .second_sigma_point_i (in_i.second_sigma_point),
    .rho_point_i          (in_i.rho_point),
    .load_value_i         (in_i.load_value),
    .sigma_a_i            (in_i.sigma_a),
    .sigma_b_i            (in_i.sigma_b),
    .covariance_i         (in_i.covariance),
    .batch_end_i          (in_i.batch_end),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .correlation_o        (out_o.correlation),
    .status_o             (out_o.status),
    .batch_end_out_o      (out_o.batch_end_out)
  );

  // A query word keeps the input closed on the following cycle.
  `CTI_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, in_i.valid && in_i.ready && in_i.kind == cti_pkg::KIND_QUERY, !in_i.ready, "query accepted but input stayed open")
  // Status codes stay within the defined set.
  `CTI_ASSERT_NOW(a_status_range, clk_i, rst_ni, out_o.valid, out_o.status <= cti_pkg::ST_FLAT, "undefined status code")
  // Zero and flat results carry a zero correlation.
  `CTI_ASSERT_NOW(a_zero_corr, clk_i, rst_ni, out_o.valid && (out_o.status == cti_pkg::ST_ZERO || out_o.status == cti_pkg::ST_FLAT), out_o.correlation == '0, "nonzero correlation on zero or flat status")
  // Saturated results sit just inside plus or minus one.
  `CTI_ASSERT_NOW(a_sat_corr, clk_i, rst_ni, out_o.valid && (out_o.status == cti_pkg::ST_ABOVE || out_o.status == cti_pkg::ST_SIGMA), out_o.correlation == cti_pkg::NEAR_ONE || out_o.correlation == -cti_pkg::NEAR_ONE, "saturated result not at near one")

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cti_pkg::*;

  localparam int SPTS = SIGMA_POINTS_DEF;
  localparam int RPTS = RHO_POINTS_DEF;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int SETTLE_CYCLES = 250;
  localparam int PHASE_WORDS = 50;

  // One input word and one expected result word.
  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [SPT_W-1:0]  p1;
    logic [SPT_W-1:0]  p2;
    logic [RPT_W-1:0]  pr;
    logic [VAL_W-1:0]  lv;
    logic [SIG_W-1:0]  sa;
    logic [SIG_W-1:0]  sb;
    logic [COV_W-1:0]  cv;
    logic              be;
  } word_t;

  typedef struct {
    logic [CORR_W-1:0] corr;
    status_e           st;
    logic              be;
  } corr_word_t;

  // Directed rows carry a typed result where one is obvious.
  typedef struct {
    word_t      w;
    bit         typed;
    corr_word_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  cti_in_if  in_ch ();
  cti_out_if out_ch ();

  correlation_table_inverter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // Shadow state of the block.
  logic [VAL_W-1:0]   cov_mem [int];
  logic [RULER_W-1:0] rho_mem [int];
  logic [CFG_W-1:0]   start_q = START_RST;
  logic [CFG_W-1:0]   step_q  = STEP_RST;
  logic [CFG_W-1:0]   recip_q = RECIP_RST;

  corr_word_t pending_corr [$];
  int errors = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_cycles = 0;

  always #4 clk_i = ~clk_i;

  // Run limit.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL correlation_table_inverter");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when asked.
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_ch.ready = 1'b0;
      hold_cycles--;
    end else begin
      out_ch.ready = ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk_i) begin
    corr_word_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_corr.size() == 0) begin
        report("unexpected word", out_ch.correlation, 0);
      end else begin
        e = pending_corr.pop_front();
        if (out_ch.correlation !== e.corr) report("correlation", out_ch.correlation, e.corr);
        if (out_ch.status !== e.st) report("status", out_ch.status, e.st);
        if (out_ch.batch_end_out !== e.be) report("batch_end_out", out_ch.batch_end_out, e.be);
      end
    end
  end

  function automatic int tbl_key(int a, int b, int r);
    return (a * SPTS + b) * RPTS + r;
  endfunction

  function automatic longint unsigned tbl_at(int a, int b, int r);
    int k;
    k = tbl_key(a, b, r);
    return cov_mem.exists(k) ? longint'(cov_mem[k]) : 0;
  endfunction

  function automatic longint rho_at(int r);
    return rho_mem.exists(r) ? longint'(rho_mem[r]) : 0;
  endfunction

  // Ruler index and upper weight of a sigma; zero when off the ruler.
  function automatic bit sigma_pos(logic [SIG_W-1:0] s, output int idx,
                                   output longint unsigned wt);
    longint unsigned prod;
    idx = 0;
    wt = 0;
    if (s < start_q) return 1'b0;
    prod = longint'(s - start_q) * longint'(recip_q);
    if ((prod >> 32) >= SPTS - 1) return 1'b0;
    idx = int'(prod >> 32);
    wt = (prod >> 16) & 64'hFFFF;
    return 1'b1;
  endfunction

  // Bilinear blend of the four corners at one rho point, Q8.24.
  function automatic longint blend_at(int ia, longint unsigned wa, int ib,
                                      longint unsigned wb, int r);
    longint unsigned ua, ub, acc;
    ua = 65536 - wa;
    ub = 65536 - wb;
    acc = tbl_at(ia, ib, r) * (ua * ub) + tbl_at(ia + 1, ib, r) * (wa * ub)
        + tbl_at(ia, ib + 1, r) * (ua * wb) + tbl_at(ia + 1, ib + 1, r) * (wa * wb);
    return longint'((acc + 64'h800000) >> 24);
  endfunction

  // Apply one accepted word to the shadow state; returns 1 with a result for queries.
  function automatic bit invert_word(word_t w, output corr_word_t res);
    bit neg;
    longint unsigned mag, wa, wb;
    longint x, p, c0, c1, den, num, corr;
    int ia, ib, lo, hi, mid;
    status_e st;
    res = '{corr: '0, st: ST_INTERP, be: 1'b0};
    if (w.kind == KIND_TABLE) begin
      cov_mem[tbl_key(w.p1, w.p2, w.pr)] = w.lv;
      return 1'b0;
    end
    if (w.kind == KIND_RULER) begin
      rho_mem[w.pr] = w.lv[RULER_W-1:0];
      return 1'b0;
    end
    if (w.kind != KIND_QUERY) return 1'b0;
    neg = w.cv[COV_W-1];
    mag = neg ? (64'h2000000 - longint'(w.cv)) : longint'(w.cv);
    corr = 0;
    if (mag == 0) begin
      st = ST_ZERO;
    end else if (!sigma_pos(w.sa, ia, wa) || !sigma_pos(w.sb, ib, wb)) begin
      st = ST_SIGMA;
      corr = NEAR_ONE;
    end else begin
      x = longint'(mag << 8);
      p = blend_at(ia, wa, ib, wb, RPTS - 1);
      if (x > p) begin
        st = ST_ABOVE;
        corr = NEAR_ONE;
      end else begin
        // Bisect; an exact hit becomes the lower point.
        lo = 0;
        hi = RPTS - 1;
        while (hi - lo > 1) begin
          mid = (lo + hi) / 2;
          p = blend_at(ia, wa, ib, wb, mid);
          if (x > p) begin
            lo = mid;
          end else if (x < p) begin
            hi = mid;
          end else begin
            lo = mid;
            break;
          end
        end
        hi = lo + 1;
        c0 = blend_at(ia, wa, ib, wb, lo);
        c1 = blend_at(ia, wa, ib, wb, hi);
        den = c1 - c0;
        if (den == 0) begin
          st = ST_FLAT;
        end else begin
          st = ST_INTERP;
          num = (rho_at(hi) - rho_at(lo)) * (x - c0);
          corr = rho_at(lo) + num / den;
          if (corr > 4194304) corr = 4194304;
          if (corr < -4194304) corr = -4194304;
        end
      end
    end
    if (neg) corr = -corr;
    res.corr = corr[CORR_W-1:0];
    res.st = st;
    res.be = w.be;
    return 1'b1;
  endfunction

  // Offer one word; predict it once it is taken.
  task automatic send_word(word_t w, bit typed = 1'b0,
                           corr_word_t typed_res = '{corr: '0, st: ST_INTERP, be: 1'b0});
    corr_word_t res;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    in_ch.kind = w.kind;
    in_ch.first_sigma_point = w.p1;
    in_ch.second_sigma_point = w.p2;
    in_ch.rho_point = w.pr;
    in_ch.load_value = w.lv;
    in_ch.sigma_a = w.sa;
    in_ch.sigma_b = w.sb;
    in_ch.covariance = w.cv;
    in_ch.batch_end = w.be;
    in_ch.valid = 1'b1;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    if (invert_word(w, res)) pending_corr.push_back(typed ? typed_res : res);
    @(negedge clk_i);
    in_ch.valid = 1'b0;
  endtask

  // Wait until the block is idle, then write one register.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    while (pending_corr.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_START: start_q = data;
      CFG_STEP:  step_q = data;
      CFG_RECIP: recip_q = data;
      default: ;
    endcase
  endtask

  // Sigma that stays in the loaded corner of the table or falls off the ruler.
  function automatic logic [SIG_W-1:0] pick_sigma();
    longint unsigned dmax, dmin, room;
    int sel;
    sel = $urandom_range(99);
    room = 64'hFFFFFF - start_q;
    if (sel < 12 && start_q > 0) return $urandom_range(start_q - 1);
    if (sel < 25) begin
      dmin = (63 * 64'h1_0000_0000 + recip_q - 1) / recip_q;
      if (dmin <= room) return start_q + dmin + $urandom_range(room - dmin);
    end
    dmax = 64'hFFFF_FFFF / recip_q;
    if (dmax > room) dmax = room;
    return start_q + $urandom_range(dmax);
  endfunction

  function automatic logic [COV_W-1:0] pick_cov();
    longint unsigned mag;
    int sel;
    sel = $urandom_range(99);
    if (sel < 8) return '0;
    if (sel < 20) return $urandom;
    if (sel < 40) mag = tbl_at($urandom_range(1), $urandom_range(1), $urandom_range(RPTS - 1));
    else mag = 1 + $urandom_range(int'(tbl_at(1, 1, RPTS - 1)));
    if (mag == 0) mag = 1;
    return $urandom_range(1) ? COV_W'(-mag) : COV_W'(mag);
  endfunction

  function automatic word_t query(logic [SIG_W-1:0] sa, logic [SIG_W-1:0] sb,
                                  logic [COV_W-1:0] cv, logic be);
    word_t w;
    w = '{default: '0};
    w.kind = KIND_QUERY;
    w.sa = sa;
    w.sb = sb;
    w.cv = cv;
    w.be = be;
    return w;
  endfunction

  function automatic word_t random_word();
    word_t w;
    int sel;
    w.p1 = $urandom;
    w.p2 = $urandom;
    w.pr = $urandom;
    w.lv = $urandom;
    w.sa = $urandom;
    w.sb = $urandom;
    w.cv = $urandom;
    w.be = $urandom;
    sel = $urandom_range(99);
    if (sel < 72) begin
      w = query(pick_sigma(), pick_sigma(), pick_cov(), $urandom);
    end else if (sel < 82) begin
      // Rewrite an entry of the corner that queries read.
      w.kind = KIND_TABLE;
      w.p1 = $urandom_range(1);
      w.p2 = $urandom_range(1);
      w.lv = $urandom_range(16000000);
    end else if (sel < 87) begin
      w.kind = KIND_TABLE;
    end else if (sel < 95) begin
      w.kind = KIND_RULER;
    end else begin
      w.kind = 2'd3;
    end
    return w;
  endfunction

  initial begin
    row_t rows [$];
    row_t r;
    word_t w;
    longint unsigned acc [4];
    longint unsigned rho_acc;
    int k;

    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.first_sigma_point = '0;
    in_ch.second_sigma_point = '0;
    in_ch.rho_point = '0;
    in_ch.load_value = '0;
    in_ch.sigma_a = '0;
    in_ch.sigma_b = '0;
    in_ch.covariance = '0;
    in_ch.batch_end = 1'b0;
    out_ch.ready = 1'b0;
    send_idle = 30;
    recv_idle = 69;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(CFG_START, 24'd0);
    write_reg(CFG_STEP, 24'd65536);
    write_reg(CFG_RECIP, 24'd65536);

    // Fill the rho ruler and the two-by-two sigma corner with rising curves;
    // a short flat run around rho point 51 lets a query land on a flat interval.
    rho_acc = $urandom_range(1000);
    foreach (acc[i]) acc[i] = $urandom_range(5000);
    for (int rp = 0; rp < RPTS; rp++) begin
      w = '{default: '0};
      w.kind = KIND_RULER;
      w.pr = rp;
      w.lv = rho_acc;
      if (rp == RPTS - 1) w.lv[VAL_W-1] = 1'b1;
      send_word(w);
      rho_acc += $urandom_range(60000);
      for (int c = 0; c < 4; c++) begin
        w.kind = KIND_TABLE;
        w.p1 = c[1];
        w.p2 = c[0];
        w.lv = acc[c];
        send_word(w);
        if (rp < 50 || rp > 53) acc[c] += $urandom_range(120000);
      end
    end

    // Directed words: zero input, off the ruler, above the table, exact hits,
    // the flat interval, extreme weights and an unused kind.
    r.typed = 1'b1;
    r.w = query(24'd0, 24'd0, '0, 1'b1);
    r.res = '{corr: '0, st: ST_ZERO, be: 1'b1};
    rows.push_back(r);
    r.w = query(24'hFFFFFF, 24'hFFFFFF, '0, 1'b0);
    r.res = '{corr: '0, st: ST_ZERO, be: 1'b0};
    rows.push_back(r);
    r.w = query(24'hFFFFFF, 24'd0, 25'd5, 1'b0);
    r.res = '{corr: NEAR_ONE, st: ST_SIGMA, be: 1'b0};
    rows.push_back(r);
    r.w = query(24'd0, 24'd4128768, -25'sd5, 1'b1);
    r.res = '{corr: -NEAR_ONE, st: ST_SIGMA, be: 1'b1};
    rows.push_back(r);
    r.w = query(24'd0, 24'd0, 25'h0FFFFFF, 1'b0);
    r.res = '{corr: NEAR_ONE, st: ST_ABOVE, be: 1'b0};
    rows.push_back(r);
    r.w = query(24'd65535, 24'd65535, 25'h1000000, 1'b1);
    r.res = '{corr: -NEAR_ONE, st: ST_ABOVE, be: 1'b1};
    rows.push_back(r);
    r.typed = 1'b0;
    r.w = query(24'd0, 24'd0, tbl_at(0, 0, 0), 1'b0);
    rows.push_back(r);
    r.w = query(24'd0, 24'd0, tbl_at(0, 0, 63), 1'b0);
    rows.push_back(r);
    r.w = query(24'd0, 24'd0, tbl_at(0, 0, RPTS - 1), 1'b1);
    rows.push_back(r);
    r.w = query(24'd0, 24'd0, -tbl_at(0, 0, 40), 1'b0);
    rows.push_back(r);
    r.w = query(24'd0, 24'd0, tbl_at(0, 0, 51), 1'b0);
    rows.push_back(r);
    r.w = query(24'd65535, 24'd65535, tbl_at(1, 1, 70) + 1, 1'b1);
    rows.push_back(r);
    r.w = query(24'd32768, 24'd12345, 25'd1, 1'b0);
    rows.push_back(r);
    r.w = query(24'd40000, 24'd1, -25'sd1, 1'b1);
    rows.push_back(r);
    r.w = '{default: '1};
    r.w.kind = 2'd3;
    rows.push_back(r);
    r.w = '{default: '1};
    r.w.kind = KIND_TABLE;
    rows.push_back(r);
    r.w = query(24'd20000, 24'd50000, tbl_at(0, 1, 90), 1'b0);
    rows.push_back(r);
    foreach (rows[i]) send_word(rows[i].w, rows[i].typed, rows[i].res);

    // Random phases under different rulers and idling patterns.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_RECIP, 24'd16777215);
          write_reg(CFG_STEP, 24'd1);
        end
        1: begin
          send_idle = 69;
          recv_idle = 30;
          write_reg(CFG_START, $urandom_range(24'h3FFFFF));
          write_reg(CFG_STEP, 1 + $urandom_range(24'hFFFFFE));
          write_reg(CFG_RECIP, 1 + $urandom_range(24'hFFFF));
        end
        2: begin
          send_idle = 0;
          recv_idle = 0;
          write_reg(CFG_START, 24'd16777215);
          write_reg(CFG_STEP, 24'd16777215);
          write_reg(CFG_RECIP, 24'd1);
        end
        default: begin
          write_reg(CFG_START, 24'd1);
          write_reg(CFG_STEP, 24'd65536);
          write_reg(CFG_RECIP, 24'd65536);
          hold_cycles = 1500;
        end
      endcase
      k = 0;
      while (k < PHASE_WORDS) begin
        w = random_word();
        send_word(w);
        k++;
      end
    end

    while (pending_corr.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS correlation_table_inverter");
    end else begin
      $display("FAIL correlation_table_inverter");
    end
    $finish;
  end

endmodule

// File: correlation_table_inverter.f
+incdir+hdl
hdl/cti_pkg.sv
hdl/cti_if.sv
hdl/cti_muldiv.sv
hdl/cti_datapath.sv
hdl/cti_controller.sv
hdl/correlation_table_inverter.sv
sim/testbench.sv
